/* src/firewire_link_register_block_assert.svh */
// Assertion macros for the register block controller.
`ifndef FIREWIRE_LINK_REGISTER_BLOCK_ASSERT_SVH
`define FIREWIRE_LINK_REGISTER_BLOCK_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define FWLRB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("register block check failed");

// Next-cycle implication, disabled while reset is held.
`define FWLRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("register block check failed");

`endif

/* src/fwlrb_pkg.sv */
package fwlrb_pkg;

  localparam int unsigned WINDOW_WORDS_DEF = 128;

  localparam int unsigned IDX_W  = 7;
  localparam int unsigned DATA_W = 32;

  // Word indexes of the special registers inside the window.
  localparam logic [IDX_W-1:0] IDX_ID0    = 7'h00;
  localparam logic [IDX_W-1:0] IDX_CTRL   = 7'h02;
  localparam logic [IDX_W-1:0] IDX_FIXED8 = 7'h04;
  localparam logic [IDX_W-1:0] IDX_PHYACC = 7'h05;
  localparam logic [IDX_W-1:0] IDX_STAT0  = 7'h08;
  localparam logic [IDX_W-1:0] IDX_MASK0  = 7'h09;
  localparam logic [IDX_W-1:0] IDX_STAT1  = 7'h0A;
  localparam logic [IDX_W-1:0] IDX_STAT2  = 7'h0C;
  localparam logic [IDX_W-1:0] IDX_ID1    = 7'h1F;

  localparam logic [DATA_W-1:0] ID0_VALUE     = 32'hFFC0_0001;
  localparam logic [DATA_W-1:0] ID1_VALUE     = 32'h1000_0001;
  localparam logic [DATA_W-1:0] PHY_WR_CLEAR  = 32'h4000_FFFF;
  localparam logic [DATA_W-1:0] PHY_RD_BIT    = 32'h8000_0000;
  localparam logic [DATA_W-1:0] PHY_WR_BIT    = 32'h4000_0000;
  localparam logic [DATA_W-1:0] CTRL_DROP_BIT = 32'h0080_0000;
  localparam logic [DATA_W-1:0] FIXED8_VALUE  = 32'h0000_0008;

  typedef struct packed {
    logic clear_en;  // write zero at the sweep address and advance it
    logic capture;   // latch the incoming word and start the store read
    logic exec;      // finish the access and load the result register
  } cmd_t;

  typedef struct packed {
    logic clear_last;  // sweep address is at the last store word
  } sts_t;

endpackage

/* src/fwlrb_ram.sv */
module fwlrb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/fwlrb_ctrl.sv */
module fwlrb_ctrl
  import fwlrb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_tvalid_i,
  output logic s_tready_o,
  output logic m_tvalid_o,
  input  logic m_tready_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

`include "firewire_link_register_block_assert.svh"

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   go;

  assign s_tready_o = (state_q == S_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  // The result register must be free, or emptied this cycle, before an access finishes.
  assign go         = (state_q == S_EXEC) && (!out_valid_q || m_tready_i);

  always_comb begin
    state_d          = state_q;
    out_valid_d      = out_valid_q;
    cmd_o.clear_en   = 1'b0;
    cmd_o.capture    = accept;
    cmd_o.exec       = go;
    if (out_valid_q && m_tready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_tvalid_o = out_valid_q;

  `FWLRB_ASSERT_NOW(a_no_accept_in_clear, clk_i, rst_ni, state_q == S_CLEAR, !s_tready_o)
  `FWLRB_ASSERT_NEXT(a_accept_to_exec, clk_i, rst_ni, accept, state_q == S_EXEC)
  `FWLRB_ASSERT_NEXT(a_exec_gives_result, clk_i, rst_ni, go, out_valid_q)

endmodule

/* src/fwlrb_dp.sv */
module fwlrb_dp
  import fwlrb_pkg::*;
#(
  parameter int unsigned WINDOW_WORDS = WINDOW_WORDS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              opcode_i,
  input  logic [IDX_W-1:0]  word_index_i,
  input  logic [DATA_W-1:0] write_data_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic [DATA_W-1:0] read_data_o,
  output logic              irq_pulse_o
);

  localparam int unsigned AW = $clog2(WINDOW_WORDS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_WORDS - 1);

  // Latched access.
  logic              op_q;
  logic [IDX_W-1:0]  idx_q;
  logic [DATA_W-1:0] wd_q;

  // Words that are read and changed by other accesses live in flip-flops.
  logic [DATA_W-1:0] stat0_q, stat0_d;
  logic [DATA_W-1:0] mask0_q, mask0_d;
  logic [7:0]        phy_q [16];
  logic              phy_we;
  logic [3:0]        phy_waddr;

  logic [AW-1:0]     clr_addr_q;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  logic [DATA_W-1:0] rd;
  logic              irq;
  logic              st_we;
  logic [DATA_W-1:0] st_wdata;
  logic              in_win;
  logic [3:0]        phy_n;
  logic [DATA_W-1:0] rd_q;
  logic              irq_q;

  assign in_win = (32'(idx_q) < 32'(WINDOW_WORDS));
  assign phy_n  = wd_q[27:24];

  always_comb begin
    rd        = '0;
    irq       = 1'b0;
    st_we     = 1'b0;
    st_wdata  = wd_q;
    stat0_d   = stat0_q;
    mask0_d   = mask0_q;
    phy_we    = 1'b0;
    phy_waddr = wd_q[11:8];
    if (!op_q) begin
      if (idx_q == IDX_ID0) begin
        rd = ID0_VALUE;
      end else if (idx_q == IDX_ID1) begin
        rd = ID1_VALUE;
      end else if (in_win) begin
        if (idx_q == IDX_STAT0) begin
          rd = stat0_q;
        end else if (idx_q == IDX_MASK0) begin
          rd = mask0_q;
        end else begin
          rd = ram_rdata;
        end
      end
    end else if (in_win) begin
      case (idx_q)
        IDX_PHYACC: begin
          st_we = 1'b1;
          if ((wd_q & PHY_WR_BIT) != '0) begin
            phy_we   = 1'b1;
            st_wdata = wd_q & ~PHY_WR_CLEAR;
          end else if ((wd_q & PHY_RD_BIT) != '0) begin
            st_wdata = (wd_q & ~PHY_RD_BIT) | {20'd0, phy_n, phy_q[phy_n]};
            if ((mask0_q & PHY_WR_BIT) != '0) begin
              stat0_d = stat0_q | PHY_WR_BIT;
              irq     = 1'b1;
            end
          end
        end
        IDX_CTRL: begin
          st_we    = 1'b1;
          st_wdata = wd_q & ~CTRL_DROP_BIT;
        end
        IDX_FIXED8: begin
          st_we    = 1'b1;
          st_wdata = FIXED8_VALUE;
        end
        IDX_STAT0: begin
          stat0_d = stat0_q & ~wd_q;
        end
        IDX_MASK0: begin
          mask0_d = wd_q;
        end
        IDX_STAT1, IDX_STAT2: begin
          st_we    = 1'b1;
          st_wdata = ram_rdata & ~wd_q;
        end
        default: begin
          st_we = 1'b1;
        end
      endcase
    end
  end

  assign ram_we    = cmd_i.clear_en || (cmd_i.exec && st_we);
  assign ram_waddr = cmd_i.clear_en ? clr_addr_q : AW'(idx_q);
  assign ram_wdata = cmd_i.clear_en ? '0 : st_wdata;

  fwlrb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WINDOW_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (AW'(word_index_i)),
    .rdata_o (ram_rdata)
  );

  assign sts_o.clear_last = (clr_addr_q == LAST_ADDR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      stat0_q    <= '0;
      mask0_q    <= '0;
      for (int i = 0; i < 16; i++) begin
        phy_q[i] <= '0;
      end
    end else begin
      if (cmd_i.clear_en) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      if (cmd_i.exec) begin
        stat0_q <= stat0_d;
        mask0_q <= mask0_d;
        if (phy_we) begin
          phy_q[phy_waddr] <= wd_q[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_i;
      idx_q <= word_index_i;
      wd_q  <= write_data_i;
    end
    if (cmd_i.exec) begin
      rd_q  <= rd;
      irq_q <= irq;
    end
  end

  assign read_data_o = rd_q;
  assign irq_pulse_o = irq_q;

endmodule

/* src/firewire_link_register_block.sv */
// Channel   Direction  Data bits (lowest first)
// s_axis    in         opcode [0], word_index [7:1], write_data [39:8]
// m_axis    out        read_data [31:0], irq_pulse [32], zero [39:33]
//
// An access has two steps: the word is taken in S_IDLE, which also starts the
// registered store read, and it finishes in S_EXEC, once the result register is
// free, when the read data is merged and any write goes back through the single
// write port. The result waits there, so a new word is taken while the previous
// result is unclaimed; only a second finished access stalls. After reset the store
// is swept to zero, one word a cycle; no word is taken meanwhile.
module firewire_link_register_block
  import fwlrb_pkg::*;
#(
  parameter int unsigned WINDOW_WORDS = WINDOW_WORDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [39:0] s_tdata_i,   // opcode, word_index, write_data
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [39:0] m_tdata_o    // read_data, irq_pulse, zero fill
);

  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] read_data;
  logic        irq_pulse;

  // The controller sequences the reset sweep, the access and the result hand-off.
  fwlrb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // The datapath holds the word store, the status, mask and PHY registers,
  // and computes the read result and the interrupt pulse.
  fwlrb_dp #(
    .WINDOW_WORDS (WINDOW_WORDS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .opcode_i     (s_tdata_i[0]),
    .word_index_i (s_tdata_i[7:1]),
    .write_data_i (s_tdata_i[39:8]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .read_data_o  (read_data),
    .irq_pulse_o  (irq_pulse)
  );

  assign m_tdata_o = {7'd0, irq_pulse, read_data};

endmodule

/* test/firewire_link_register_block_test.sv */
`timescale 1ns / 100ps

module firewire_link_register_block_test;
  import fwlrb_pkg::*;

  localparam logic OP_READ = 1'b0;
  localparam logic OP_WRITE = 1'b1;
  localparam logic [DATA_W-1:0] PHY_IRQ_BIT = 32'h4000_0000;
  localparam int unsigned STORE_WORDS = 128;
  localparam int unsigned RANDOM_ACCESSES = 1100;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic irq_pulse;
  } link_result_t;

  // Mirror of the register window and the PHY byte bank. Every accepted word
  // updates the mirror and queues the result the block owes for it.
  class link_reg_scoreboard;
    logic [DATA_W-1:0] window_regs [STORE_WORDS];
    logic [7:0] phy_regs [16];
    link_result_t owed_q [$];
    int unsigned accesses;
    int unsigned results;
    int unsigned irq_count;
    int unsigned mismatches;

    function new();
      foreach (window_regs[i]) window_regs[i] = '0;
      foreach (phy_regs[i]) phy_regs[i] = '0;
      accesses = 0;
      results = 0;
      irq_count = 0;
      mismatches = 0;
    endfunction

    function void note_access(logic op, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      link_result_t res;
      logic [DATA_W-1:0] acc;
      logic [3:0] n;
      res = '0;
      accesses++;
      if (op == OP_READ) begin
        if (idx == IDX_ID0) begin
          res.read_data = ID0_VALUE;
        end else if (idx == IDX_ID1) begin
          res.read_data = ID1_VALUE;
        end else begin
          res.read_data = window_regs[idx];
        end
      end else begin
        case (idx)
          IDX_PHYACC: begin
            acc = data;
            // A set write bit wins over a set read bit.
            if ((data & PHY_WR_BIT) != '0) begin
              phy_regs[acc[11:8]] = acc[7:0];
              acc &= ~PHY_WR_CLEAR;
            end else if ((data & PHY_RD_BIT) != '0) begin
              n = acc[27:24];
              acc &= ~PHY_RD_BIT;
              acc |= {20'd0, n, phy_regs[n]};
              if ((window_regs[IDX_MASK0] & PHY_IRQ_BIT) != '0) begin
                window_regs[IDX_STAT0] |= PHY_IRQ_BIT;
                res.irq_pulse = 1'b1;
                irq_count++;
              end
            end
            window_regs[IDX_PHYACC] = acc;
          end
          IDX_CTRL: window_regs[idx] = data & ~CTRL_DROP_BIT;
          IDX_FIXED8: window_regs[idx] = FIXED8_VALUE;
          IDX_STAT0, IDX_STAT1, IDX_STAT2: window_regs[idx] &= ~data;
          default: window_regs[idx] = data;
        endcase
      end
      owed_q.push_back(res);
    endfunction

    function void check_result(logic [DATA_W-1:0] rd, logic irq);
      link_result_t exp_res;
      results++;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unexpected result: read_data %08h irq_pulse %0b", rd, irq);
        end
      end else begin
        exp_res = owed_q.pop_front();
        if (rd !== exp_res.read_data || irq !== exp_res.irq_pulse) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("result %0d: read_data %08h irq_pulse %0b, expected %08h %0b",
                     results, rd, irq, exp_res.read_data, exp_res.irq_pulse);
          end
        end
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid_i = 1'b0;
  logic s_tready_o;
  logic [39:0] s_tdata_i = '0;  // opcode, word_index, write_data
  logic m_tvalid_o;
  logic m_tready_i = 1'b0;
  logic [39:0] m_tdata_o;  // read_data, irq_pulse, zero fill

  link_reg_scoreboard sb = new();
  logic [IDX_W-1:0] hot_idx [9] = '{IDX_ID0, IDX_CTRL, IDX_FIXED8, IDX_PHYACC, IDX_STAT0,
                                    IDX_MASK0, IDX_STAT1, IDX_STAT2, IDX_ID1};
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned holds_done = 0;

  firewire_link_register_block dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i(s_tdata_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o(m_tdata_o)
  );

  always #2 clk_i = ~clk_i;

  // Offers one word and returns at the edge that takes it. Bursts of random
  // length are separated by random gaps, some of them empty.
  task automatic offer_access(input logic op, input logic [IDX_W-1:0] idx,
                              input logic [DATA_W-1:0] data);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        s_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i <= {data, idx, op};
    do @(posedge clk_i); while (!s_tready_o);
    sb.note_access(op, idx, data);
    burst_left--;
  endtask

  // One PHY round trip with random content: mask, PHY write, PHY read, and a
  // look at the access and status words before the status is cleared again.
  task automatic phy_round_trip();
    logic [3:0] n;
    logic [DATA_W-1:0] r;
    n = 4'($urandom_range(0, 15));
    r = $urandom();
    offer_access(OP_WRITE, IDX_MASK0, $urandom());
    offer_access(OP_WRITE, IDX_PHYACC, {r[31], 1'b1, r[29:12], n, r[7:0]});
    offer_access(OP_WRITE, IDX_PHYACC, {1'b1, 1'b0, r[29:28], n, r[23:0]});
    offer_access(OP_READ, IDX_PHYACC, $urandom());
    offer_access(OP_READ, IDX_STAT0, $urandom());
    offer_access(OP_WRITE, IDX_STAT0, $urandom());
  endtask

  task automatic single_access();
    logic op;
    logic [IDX_W-1:0] idx;
    logic [DATA_W-1:0] data;
    op = 1'($urandom_range(0, 1));
    idx = $urandom_range(0, 1) ? hot_idx[$urandom_range(0, 8)] : IDX_W'($urandom_range(0, 127));
    data = $urandom();
    case ($urandom_range(0, 3))
      0: data[31:30] = 2'b01;
      1: data[31:30] = 2'b10;
      2: data[31:30] = 2'b11;
      default: ;
    endcase
    offer_access(op, idx, data);
  endtask

  // Receiver: checks each taken result and picks the next ready value from a
  // pattern that rotates through several shapes. Twice it holds off for a long
  // stretch so the block backs up into its input.
  initial begin
    int unsigned rx_cycle;
    int unsigned hold_left;
    logic next_ready;
    rx_cycle = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_tvalid_o && m_tready_i) begin
        sb.check_result(m_tdata_o[31:0], m_tdata_o[32]);
      end
      if (hold_left == 0 && holds_done < 2 && sb.results >= 300 + 400 * holds_done) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left != 0) begin
        next_ready = 1'b0;
        hold_left--;
      end else begin
        case ((rx_cycle / 97) % 4)
          0: next_ready = 1'b1;
          1: next_ready = (rx_cycle % 4) != 0;
          2: next_ready = 1'($urandom_range(0, 1));
          default: next_ready = $urandom_range(0, 4) == 0;
        endcase
      end
      m_tready_i <= next_ready;
      rx_cycle++;
    end
  end

  // Watchdog: a run that stops moving words in either direction is broken.
  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("no word moved for %0d cycles", IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Identity words, including a write that must not show through.
    offer_access(OP_READ, IDX_ID0, 32'h0);
    offer_access(OP_READ, IDX_ID1, 32'hFFFF_FFFF);
    offer_access(OP_WRITE, IDX_ID0, 32'hFFFF_FFFF);
    offer_access(OP_READ, IDX_ID0, 32'h0);
    offer_access(OP_WRITE, IDX_ID1, 32'h0);
    offer_access(OP_READ, IDX_ID1, 32'h0);
    // Control word drops bit 23; the fixed word ignores its data.
    offer_access(OP_WRITE, IDX_CTRL, 32'hFFFF_FFFF);
    offer_access(OP_READ, IDX_CTRL, 32'h0);
    offer_access(OP_WRITE, IDX_FIXED8, 32'hFFFF_FFFF);
    offer_access(OP_READ, IDX_FIXED8, 32'h0);
    // PHY traffic with the interrupt enabled, both PHY bits set first.
    offer_access(OP_WRITE, IDX_MASK0, PHY_IRQ_BIT);
    offer_access(OP_WRITE, IDX_PHYACC, 32'hC000_05A5);
    offer_access(OP_READ, IDX_PHYACC, 32'h0);
    offer_access(OP_WRITE, IDX_PHYACC, 32'h8500_0000);
    offer_access(OP_READ, IDX_STAT0, 32'h0);
    offer_access(OP_WRITE, IDX_STAT0, PHY_IRQ_BIT);
    offer_access(OP_READ, IDX_STAT0, 32'h0);
    // Interrupt masked: a PHY read must stay quiet.
    offer_access(OP_WRITE, IDX_MASK0, 32'h0);
    offer_access(OP_WRITE, IDX_PHYACC, 32'h8F00_0000);
    offer_access(OP_WRITE, IDX_PHYACC, 32'h4000_0FFF);
    offer_access(OP_WRITE, IDX_PHYACC, 32'h8F00_0000);
    offer_access(OP_READ, IDX_PHYACC, 32'h0);
    // Top of the window and the other status words.
    offer_access(OP_WRITE, 7'h7F, 32'hFFFF_FFFF);
    offer_access(OP_READ, 7'h7F, 32'h0);
    offer_access(OP_WRITE, IDX_STAT1, 32'hFFFF_FFFF);

    while (sb.accesses < RANDOM_ACCESSES + 25) begin
      if ($urandom_range(0, 9) < 6) begin
        phy_round_trip();
      end else begin
        single_access();
      end
    end
    s_tvalid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d accesses, %0d results, %0d PHY interrupts, %0d long receiver holds",
             sb.accesses, sb.results, sb.irq_count, holds_done);
    $display("%0d mismatches, %0d results still owed", sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
